>>> src/hcbp_pkg.sv
`timescale 1ns / 1ps
// Package for the Huffman code bit packer: beat types, command codes and
// default sizes. Used by every module of the block but hcbp_ram; depends on nothing.
package hcbp_pkg;

  localparam int unsigned SYMBOL_COUNT_DEF = 256;
  localparam int unsigned MAX_CODE_LEN_DEF = 32;

  localparam int unsigned CMD_W       = 2;
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned CODE_WORD_W = 32;
  localparam int unsigned CODE_LEN_W  = 6;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned TAIL_BITS_W = 4;
  // Leftover bits between beats never reach a full byte.
  localparam int unsigned RES_W       = 7;
  localparam int unsigned RES_CNT_W   = 3;

  localparam logic [TAIL_BITS_W-1:0] TAIL_NONE = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_ENCODE = 2'd1,
    CMD_FLUSH  = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [CMD_W-1:0]       cmd;
    logic [SYM_W-1:0]       symbol;
    logic [CODE_WORD_W-1:0] code_word;
    logic [CODE_LEN_W-1:0]  code_length;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0]      byte_value;
    logic                   is_tail;
    logic [TAIL_BITS_W-1:0] tail_bits;
    logic                   last;
  } out_t;

  // Control half of a job handed from the packer to the emitter.
  typedef struct packed {
    logic                   valid;
    logic                   tail;
    logic [TAIL_BITS_W-1:0] tail_bits;
  } job_ctl_t;

endpackage

>>> src/hcbp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Standalone; no package needed.
module hcbp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/hcbp_pack.sv
`timescale 1ns / 1ps
// Input side of the bit packer: code table RAM, lookup stage and residual bit buffer.
// Builds a job per flush and per encode that completes a byte. Uses hcbp_pkg, hcbp_ram.
module hcbp_pack
  import hcbp_pkg::*;
#(
  parameter int unsigned SymbolCount = SYMBOL_COUNT_DEF,
  parameter int unsigned MaxCodeLen  = MAX_CODE_LEN_DEF,
  localparam int unsigned AccW = RES_W + MaxCodeLen,
  localparam int unsigned RemW = $clog2(AccW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  in_t             in_data_i,
  input  logic            job_free_i,
  output job_ctl_t        job_ctl_o,
  output logic [AccW-1:0] job_acc_o,
  output logic [RemW-1:0] job_rem_o
);

  localparam int unsigned AddrW  = $clog2(SymbolCount);
  localparam int unsigned LenW   = $clog2(MaxCodeLen + 1);
  localparam int unsigned CodeW  = (MaxCodeLen < CODE_WORD_W) ? MaxCodeLen : CODE_WORD_W;
  localparam int unsigned EntryW = CodeW + LenW;

  logic             accept;
  logic             in_range;
  logic [LenW-1:0]  len_sat;
  logic [CodeW-1:0] code_masked;
  logic             ram_we;
  logic             ram_re;
  logic [EntryW-1:0] ram_rdata;

  logic             s1_valid_q, s1_valid_d;
  logic             s1_flush_q, s1_flush_d;
  logic             s1_hit_q, s1_hit_d;
  logic [RES_W-1:0]     res_q, res_d;
  logic [RES_CNT_W-1:0] cnt_q, cnt_d;

  logic             s1_go;
  logic [LenW-1:0]  clen;
  logic [CodeW-1:0] code;
  logic [AccW-1:0]  acc;
  logic [RemW-1:0]  total;

  assign in_stall_o = s1_valid_q && !job_free_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = {1'b0, in_data_i.symbol} < (SYM_W + 1)'(SymbolCount);

  // Saturate the length, then drop code bits above it.
  assign len_sat = (in_data_i.code_length > CODE_LEN_W'(MaxCodeLen)) ?
                   LenW'(MaxCodeLen) : LenW'(in_data_i.code_length);
  assign code_masked = in_data_i.code_word[CodeW-1:0] & ~({CodeW{1'b1}} << len_sat);

  assign ram_we = accept && (in_data_i.cmd == CMD_LOAD) && in_range;
  assign ram_re = accept && (in_data_i.cmd == CMD_ENCODE);

  hcbp_ram #(
    .Width(EntryW),
    .Depth(SymbolCount)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(in_data_i.symbol[AddrW-1:0]),
    .wdata_i({len_sat, code_masked}),
    .re_i   (ram_re),
    .raddr_i(in_data_i.symbol[AddrW-1:0]),
    .rdata_o(ram_rdata)
  );

  // The lookup stage holds while the emitter is busy; the RAM output holds
  // with it because no read is issued while the input is stalled.
  assign s1_go = s1_valid_q && job_free_i;

  always_comb begin
    s1_valid_d = s1_valid_q && !s1_go;
    s1_flush_d = s1_flush_q;
    s1_hit_d   = s1_hit_q;
    if (accept) begin
      case (in_data_i.cmd)
        CMD_ENCODE: begin
          s1_valid_d = 1'b1;
          s1_flush_d = 1'b0;
          s1_hit_d   = in_range;
        end
        CMD_FLUSH: begin
          s1_valid_d = 1'b1;
          s1_flush_d = 1'b1;
          s1_hit_d   = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign clen  = s1_hit_q ? ram_rdata[EntryW-1:CodeW] : '0;
  assign code  = s1_hit_q ? ram_rdata[CodeW-1:0] : '0;
  assign acc   = (AccW'(res_q) << clen) | AccW'(code);
  assign total = RemW'(cnt_q) + RemW'(clen);

  always_comb begin
    res_d           = res_q;
    cnt_d           = cnt_q;
    job_ctl_o       = '0;
    job_acc_o       = acc;
    job_rem_o       = total;
    if (s1_go) begin
      if (s1_flush_q) begin
        job_ctl_o.valid     = 1'b1;
        job_ctl_o.tail      = 1'b1;
        job_ctl_o.tail_bits = (cnt_q == '0) ? TAIL_NONE : TAIL_BITS_W'(cnt_q);
        job_acc_o           = AccW'(res_q);
        job_rem_o           = '0;
        res_d               = '0;
        cnt_d               = '0;
      end else begin
        job_ctl_o.valid = (total[RemW-1:3] != '0);
        res_d           = acc[RES_W-1:0] & ~({RES_W{1'b1}} << total[2:0]);
        cnt_d           = total[2:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_flush_q <= 1'b0;
      s1_hit_q   <= 1'b0;
      res_q      <= '0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s1_flush_q <= s1_flush_d;
      s1_hit_q   <= s1_hit_d;
      res_q      <= res_d;
      cnt_q      <= cnt_d;
    end
  end

`ifndef SYNTHESIS
  a_res_masked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_q >> cnt_q) == '0)
    else $error("residual holds bits above its count");

  a_flush_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && s1_flush_q |=> cnt_q == '0 && res_q == '0)
    else $error("flush did not empty the residual buffer");

  a_data_job_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ctl_o.valid && !job_ctl_o.tail |-> job_rem_o >= RemW'(BYTE_W))
    else $error("data job issued with less than one byte");
`endif

endmodule

>>> src/hcbp_emit.sv
`timescale 1ns / 1ps
// Output side of the bit packer: job register that peels bytes off the packed
// bits, one per cycle unless the output stalls, and the output register. Uses hcbp_pkg.
module hcbp_emit
  import hcbp_pkg::*;
#(
  parameter int unsigned MaxCodeLen = MAX_CODE_LEN_DEF,
  localparam int unsigned AccW = RES_W + MaxCodeLen,
  localparam int unsigned RemW = $clog2(AccW + 1)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  job_ctl_t        job_ctl_i,
  input  logic [AccW-1:0] job_acc_i,
  input  logic [RemW-1:0] job_rem_i,
  output logic            job_free_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output out_t            out_data_o
);

  logic                   job_valid_q, job_valid_d;
  logic                   job_tail_q, job_tail_d;
  logic [TAIL_BITS_W-1:0] job_bits_q, job_bits_d;
  logic [AccW-1:0]        job_acc_q, job_acc_d;
  logic [RemW-1:0]        job_rem_q, job_rem_d;
  logic                   out_valid_q, out_valid_d;
  out_t                   out_q, out_d;

  logic            out_free;
  logic            take;
  logic            is_last;
  logic [RemW-1:0] rem_less;
  out_t            beat;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign take       = job_valid_q && out_free;
  // Bits still left after this byte; the byte sits just above them.
  assign rem_less   = job_rem_q - RemW'(BYTE_W);
  assign is_last    = job_tail_q || (rem_less[RemW-1:3] == '0);
  assign job_free_o = !job_valid_q || (take && is_last);

  always_comb begin
    beat.is_tail = job_tail_q;
    beat.last    = is_last;
    if (job_tail_q) begin
      beat.byte_value = job_acc_q[BYTE_W-1:0];
      beat.tail_bits  = job_bits_q;
    end else begin
      beat.byte_value = BYTE_W'(job_acc_q >> rem_less);
      beat.tail_bits  = TAIL_NONE;
    end
  end

  always_comb begin
    job_valid_d = job_valid_q;
    job_tail_d  = job_tail_q;
    job_bits_d  = job_bits_q;
    job_acc_d   = job_acc_q;
    job_rem_d   = job_rem_q;
    if (job_ctl_i.valid) begin
      job_valid_d = 1'b1;
      job_tail_d  = job_ctl_i.tail;
      job_bits_d  = job_ctl_i.tail_bits;
      job_acc_d   = job_acc_i;
      job_rem_d   = job_rem_i;
    end else if (take) begin
      job_valid_d = !is_last;
      job_rem_d   = rem_less;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (take) begin
      out_valid_d = 1'b1;
      out_d       = beat;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      job_valid_q <= job_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_tail_q <= job_tail_d;
    job_bits_q <= job_bits_d;
    job_acc_q  <= job_acc_d;
    job_rem_q  <= job_rem_d;
    out_q      <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ctl_i.valid |-> job_free_o)
    else $error("job loaded over one still in progress");

  a_job_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_q && !job_tail_q |-> job_rem_q >= RemW'(BYTE_W))
    else $error("data job holds less than a full byte");

  a_tail_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.is_tail |-> out_q.last)
    else $error("tail beat not marked last");
`endif

endmodule

>>> src/huffman_code_bit_packer.sv
`timescale 1ns / 1ps
// Huffman code bit packer, top level. An item passes the table read, the job
// register and the output register. The input takes one item per cycle
// unless stalled. An item that completes bytes keeps the emitter busy while
// the job register sends them, one byte per cycle unless the output stalls.
// Reset clears the residual buffer and the pipeline; the code table has no
// reset and must be loaded before a symbol is encoded. Uses hcbp_pkg.
module huffman_code_bit_packer
  import hcbp_pkg::*;
#(
  parameter int unsigned SYMBOL_COUNT = SYMBOL_COUNT_DEF,
  parameter int unsigned MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  localparam int unsigned AccW = RES_W + MAX_CODE_LEN;
  localparam int unsigned RemW = $clog2(AccW + 1);

  job_ctl_t        job_ctl;
  logic [AccW-1:0] job_acc;
  logic [RemW-1:0] job_rem;
  logic            job_free;

  hcbp_pack #(
    .SymbolCount(SYMBOL_COUNT),
    .MaxCodeLen (MAX_CODE_LEN)
  ) u_pack (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .job_free_i(job_free),
    .job_ctl_o (job_ctl),
    .job_acc_o (job_acc),
    .job_rem_o (job_rem)
  );

  hcbp_emit #(
    .MaxCodeLen(MAX_CODE_LEN)
  ) u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_ctl_i  (job_ctl),
    .job_acc_i  (job_acc),
    .job_rem_i  (job_rem),
    .job_free_o (job_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

endmodule
